>>> design/goa_pkg.sv
// Shared types and constants for the gyro offset averager.
`timescale 1ns / 1ps
package goa_pkg;

  localparam int RATE_W   = 24;
  localparam int COUNT_W  = 16;
  localparam int SUM_W    = RATE_W + COUNT_W;
  localparam int STEP_W   = $clog2(SUM_W);
  localparam int NUM_AXES = 3;

  localparam logic [COUNT_W-1:0] DEFAULT_ATTEMPTS = COUNT_W'(100);
  localparam logic [STEP_W-1:0]  LAST_STEP        = STEP_W'(SUM_W - 1);

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_VALID  = 2'd1,
    STS_NOT_READY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic               clear;
    logic               add;
    logic               load;
    logic               step;
    logic [COUNT_W-1:0] divisor;
  } lane_ctrl_t;

  typedef struct packed {
    logic    clear;
    logic    commit;
    logic    emit;
    status_t status;
  } merge_ctrl_t;

endpackage

>>> design/goa_lane.sv
// One axis lane: 40-bit accumulator and a bit-serial signed divider.
`timescale 1ns / 1ps
module goa_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  goa_pkg::lane_ctrl_t               ctrl,
  input  logic signed [goa_pkg::RATE_W-1:0] rate,
  output logic signed [goa_pkg::RATE_W-1:0] mean
);

  logic [goa_pkg::SUM_W-1:0]   acc_r, acc_nxt;
  logic [goa_pkg::SUM_W-1:0]   quo_r, quo_nxt;
  logic [goa_pkg::COUNT_W-1:0] rem_r, rem_nxt;
  logic [goa_pkg::COUNT_W-1:0] div_r, div_nxt;
  logic                        neg_r, neg_nxt;

  logic [goa_pkg::COUNT_W:0]   trial;
  logic [goa_pkg::COUNT_W:0]   trial_sub;
  logic                        trial_ge;
  logic [goa_pkg::SUM_W-1:0]   acc_mag;
  logic [goa_pkg::SUM_W-1:0]   quo_signed;

  always_comb begin
    acc_mag   = acc_r[goa_pkg::SUM_W-1] ? (~acc_r + 1'b1) : acc_r;
    trial     = {rem_r, quo_r[goa_pkg::SUM_W-1]};
    trial_ge  = trial >= {1'b0, div_r};
    trial_sub = trial - {1'b0, div_r};

    acc_nxt = acc_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    neg_nxt = neg_r;

    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.add) begin
      acc_nxt = acc_r + {{(goa_pkg::SUM_W - goa_pkg::RATE_W){rate[goa_pkg::RATE_W-1]}}, rate};
    end

    if (ctrl.load) begin
      // divide magnitudes, fix the sign at the end (truncates toward zero)
      quo_nxt = acc_mag;
      rem_nxt = '0;
      div_nxt = ctrl.divisor;
      neg_nxt = acc_r[goa_pkg::SUM_W-1];
    end else if (ctrl.step) begin
      rem_nxt = trial_ge ? trial_sub[goa_pkg::COUNT_W-1:0] : trial[goa_pkg::COUNT_W-1:0];
      quo_nxt = {quo_r[goa_pkg::SUM_W-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  // mean always fits the rate width
  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign mean       = quo_signed[goa_pkg::RATE_W-1:0];

endmodule

>>> design/goa_ctrl.sv
// Run sequencer: attempt and valid counters, end-of-run check, divide steps.
`timescale 1ns / 1ps
module goa_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         in_kind,
  input  logic                         in_device_ready,
  input  logic                         in_read_ok,
  input  logic                         cfg_we,
  input  logic [goa_pkg::COUNT_W-1:0]  cfg_wdata,
  output logic                         busy,
  output goa_pkg::lane_ctrl_t          lane_ctrl,
  output goa_pkg::merge_ctrl_t         merge_ctrl
);

  goa_pkg::ctrl_state_t        state_r, state_nxt;
  logic [goa_pkg::COUNT_W-1:0] sample_count_r, sample_count_nxt;
  logic [goa_pkg::COUNT_W-1:0] valid_r, valid_nxt;
  logic [goa_pkg::COUNT_W-1:0] attempts_r, attempts_nxt;
  logic                        run_r, run_nxt;
  logic [goa_pkg::STEP_W-1:0]  step_r, step_nxt;

  logic                        accept;
  logic [goa_pkg::COUNT_W-1:0] target;
  logic [goa_pkg::COUNT_W-1:0] valid_inc;
  logic [goa_pkg::COUNT_W-1:0] attempts_inc;
  logic                        run_end;

  always_comb begin
    busy   = state_r != goa_pkg::S_IDLE;
    accept = start && !busy;

    target       = (sample_count_r == '0) ? goa_pkg::DEFAULT_ATTEMPTS : sample_count_r;
    valid_inc    = valid_r + goa_pkg::COUNT_W'(in_read_ok);
    attempts_inc = attempts_r + 1'b1;
    run_end      = (attempts_inc >= target) || (attempts_inc == '0);

    sample_count_nxt = cfg_we ? cfg_wdata : sample_count_r;
    state_nxt        = state_r;
    valid_nxt        = valid_r;
    attempts_nxt     = attempts_r;
    run_nxt          = run_r;
    step_nxt         = step_r;

    lane_ctrl         = '0;
    lane_ctrl.divisor = valid_r;
    merge_ctrl        = '0;
    merge_ctrl.status = goa_pkg::STS_OK;

    unique case (state_r)
      goa_pkg::S_IDLE: begin
        if (accept && !in_kind) begin
          if (!in_device_ready) begin
            merge_ctrl.emit   = 1'b1;
            merge_ctrl.status = goa_pkg::STS_NOT_READY;
          end else begin
            lane_ctrl.clear  = 1'b1;
            merge_ctrl.clear = 1'b1;
            valid_nxt        = '0;
            attempts_nxt     = '0;
            run_nxt          = 1'b1;
          end
        end else if (accept && run_r) begin
          lane_ctrl.add = in_read_ok;
          valid_nxt     = valid_inc;
          attempts_nxt  = attempts_inc;
          if (run_end) begin
            run_nxt = 1'b0;
            if (valid_inc == '0) begin
              merge_ctrl.emit   = 1'b1;
              merge_ctrl.status = goa_pkg::STS_NO_VALID;
            end else begin
              state_nxt = goa_pkg::S_LOAD;
            end
          end
        end
      end
      goa_pkg::S_LOAD: begin
        lane_ctrl.load = 1'b1;
        step_nxt       = '0;
        state_nxt      = goa_pkg::S_DIV;
      end
      goa_pkg::S_DIV: begin
        lane_ctrl.step = 1'b1;
        step_nxt       = step_r + 1'b1;
        if (step_r == goa_pkg::LAST_STEP) begin
          state_nxt = goa_pkg::S_DONE;
        end
      end
      goa_pkg::S_DONE: begin
        merge_ctrl.commit = 1'b1;
        merge_ctrl.emit   = 1'b1;
        merge_ctrl.status = goa_pkg::STS_OK;
        state_nxt         = goa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = goa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= goa_pkg::S_IDLE;
      sample_count_r <= goa_pkg::DEFAULT_ATTEMPTS;
      valid_r        <= '0;
      attempts_r     <= '0;
      run_r          <= 1'b0;
      step_r         <= '0;
    end else begin
      state_r        <= state_nxt;
      sample_count_r <= sample_count_nxt;
      valid_r        <= valid_nxt;
      attempts_r     <= attempts_nxt;
      run_r          <= run_nxt;
      step_r         <= step_nxt;
    end
  end

endmodule

>>> design/goa_merge.sv
// Merge stage: stored offsets, calibrated flag and the result register.
`timescale 1ns / 1ps
module goa_merge (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  goa_pkg::merge_ctrl_t                            ctrl,
  input  logic [goa_pkg::NUM_AXES-1:0][goa_pkg::RATE_W-1:0] lane_mean,
  output logic                                            out_valid,
  output logic [1:0]                                      out_status,
  output logic                                            out_calibrated,
  output logic [goa_pkg::NUM_AXES-1:0][goa_pkg::RATE_W-1:0] out_offset
);

  logic [goa_pkg::NUM_AXES-1:0][goa_pkg::RATE_W-1:0] offs_r, offs_nxt;
  logic                                              cal_r, cal_nxt;
  logic                                              valid_r;
  logic [1:0]                                        status_r;
  logic                                              ocal_r;
  logic [goa_pkg::NUM_AXES-1:0][goa_pkg::RATE_W-1:0] ooffs_r;

  always_comb begin
    offs_nxt = offs_r;
    cal_nxt  = cal_r;
    if (ctrl.clear) begin
      offs_nxt = '0;
      cal_nxt  = 1'b0;
    end else if (ctrl.commit) begin
      offs_nxt = lane_mean;
      cal_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offs_r  <= '0;
      cal_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      offs_r  <= offs_nxt;
      cal_r   <= cal_nxt;
      valid_r <= ctrl.emit;
    end
  end

  // result beat reflects the updated stored state
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      status_r <= ctrl.status;
      ocal_r   <= cal_nxt;
      ooffs_r  <= offs_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_calibrated = ocal_r;
  assign out_offset     = ooffs_r;

endmodule

>>> design/gyro_offset_averager_core.sv
// Gyro zero-rate offset calibration: top level with three axis lanes.
// A not-ready start or an empty run gives its result beat in the cycle after accept.
// With valid readings: S_LOAD, the 40-step S_DIV, S_DONE, then the result register beat.
// Throughput: one item per cycle while not busy; busy stays high from S_LOAD to S_DONE.
// Reset: sample_count 100, offsets zero, not calibrated, no run; no clearing pass.
// Results cannot be stalled: out_valid marks each beat for one cycle.
`timescale 1ns / 1ps
module gyro_offset_averager_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_kind,
  input  logic                              in_device_ready,
  input  logic                              in_read_ok,
  input  logic signed [goa_pkg::RATE_W-1:0] in_rate_x,
  input  logic signed [goa_pkg::RATE_W-1:0] in_rate_y,
  input  logic signed [goa_pkg::RATE_W-1:0] in_rate_z,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic                              out_calibrated,
  output logic signed [goa_pkg::RATE_W-1:0] out_offset_x,
  output logic signed [goa_pkg::RATE_W-1:0] out_offset_y,
  output logic signed [goa_pkg::RATE_W-1:0] out_offset_z,
  input  logic                              cfg_we,
  input  logic [goa_pkg::COUNT_W-1:0]       cfg_wdata
);

  goa_pkg::lane_ctrl_t                               lane_ctrl;
  goa_pkg::merge_ctrl_t                              merge_ctrl;
  logic [goa_pkg::NUM_AXES-1:0][goa_pkg::RATE_W-1:0] lane_rate;
  logic [goa_pkg::NUM_AXES-1:0][goa_pkg::RATE_W-1:0] lane_mean;
  logic [goa_pkg::NUM_AXES-1:0][goa_pkg::RATE_W-1:0] offset;

  assign lane_rate[0] = in_rate_x;
  assign lane_rate[1] = in_rate_y;
  assign lane_rate[2] = in_rate_z;

  goa_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_kind         (in_kind),
    .in_device_ready (in_device_ready),
    .in_read_ok      (in_read_ok),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .busy            (busy),
    .lane_ctrl       (lane_ctrl),
    .merge_ctrl      (merge_ctrl)
  );

  for (genvar a = 0; a < goa_pkg::NUM_AXES; a++) begin : g_lane
    goa_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl),
      .rate  (lane_rate[a]),
      .mean  (lane_mean[a])
    );
  end

  goa_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (merge_ctrl),
    .lane_mean      (lane_mean),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_calibrated (out_calibrated),
    .out_offset     (offset)
  );

  assign out_offset_x = offset[0];
  assign out_offset_y = offset[1];
  assign out_offset_z = offset[2];

endmodule
